>>> src/assert_macros.svh
// Assertion macros shared by the polyline grid walker RTL.
// Needs signals named clk and rst_n in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> src/pgw_pkg.sv
// Package of the polyline grid walker: sizes, walk command type, mode codes.
// No dependencies; used by every file of the block but assert_macros.svh.
package pgw_pkg;

  localparam int GRID_SIZE   = 64;
  localparam int FRAC_BITS   = 16;
  localparam int COORD_W     = 6;
  localparam int MAX_RES     = 64;
  localparam int QUEUE_DEPTH = 2;

  // Carried coordinate: one guard bit above the grid index, then the fraction.
  localparam int CARRY_W = COORD_W + 1 + FRAC_BITS;
  // Slope dividend / quotient width and the slope magnitude width (at most one).
  localparam int NUM_W   = COORD_W + FRAC_BITS;
  localparam int DMAG_W  = FRAC_BITS + 1;
  localparam int RCNT_W  = $clog2(MAX_RES);

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [1:0]         mode_t;

  localparam coord_t COORD_MAX = COORD_W'(GRID_SIZE - 1);

  localparam mode_t MODE_SINGLE  = 2'd0;
  localparam mode_t MODE_SHALLOW = 2'd1;
  localparam mode_t MODE_STEEP   = 2'd2;

  typedef struct packed {
    mode_t             mode;
    coord_t            x_start;
    coord_t            y_start;
    coord_t            x_end;
    coord_t            y_end;
    logic              d_neg;
    logic [DMAG_W-1:0] d_mag;
  } walk_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic coord_t sat_coord(input coord_t v);
    return (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

endpackage

>>> src/pgw_ifs.sv
// Valid/ready channel interfaces of the polyline grid walker.
// Depends on pgw_pkg for the coordinate type.
interface pgw_in_if;
  import pgw_pkg::*;
  logic   valid;
  logic   ready;
  logic   new_line;
  coord_t vertex_x;
  coord_t vertex_y;

  modport source (output valid, new_line, vertex_x, vertex_y, input ready);
  modport sink   (input valid, new_line, vertex_x, vertex_y, output ready);
endinterface

interface pgw_out_if;
  import pgw_pkg::*;
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;
  logic   last_point;

  modport source (output valid, point_x, point_y, last_point, input ready);
  modport sink   (input valid, point_x, point_y, last_point, output ready);
endinterface

>>> src/pgw_front.sv
// Front end: accepts vertices, keeps the previous vertex, classifies the segment
// and computes its slope with a bit-serial divider. Depends on pgw_pkg, pgw_ifs.
`include "assert_macros.svh"

module pgw_front (
  input  logic               clk,
  input  logic               rst_n,
  pgw_in_if.sink             in_vtx,
  output logic               push_o,
  output pgw_pkg::walk_cmd_t cmd_o,
  input  pgw_pkg::q_stat_t   q_stat_i
);
  import pgw_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_PUSH = 2'd2;
  localparam int DCNT_W = $clog2(NUM_W);

  logic [1:0]        state_r, state_nxt;
  coord_t            prev_x_r, prev_x_nxt;
  coord_t            prev_y_r, prev_y_nxt;
  logic              started_r, started_nxt;
  walk_cmd_t         cmd_r, cmd_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  coord_t            rem_r, rem_nxt;
  coord_t            div_r, div_nxt;
  logic [DCNT_W-1:0] cnt_r, cnt_nxt;

  coord_t       vx, vy, adx, ady;
  logic         x_neg, y_neg, shallow, is_start, is_repeat, accept;
  logic [COORD_W:0] rem_sh, rem_diff;
  logic         rem_ge;

  assign in_vtx.ready = (state_r == ST_IDLE);
  assign accept       = in_vtx.valid && in_vtx.ready;

  always_comb begin
    vx        = sat_coord(in_vtx.vertex_x);
    vy        = sat_coord(in_vtx.vertex_y);
    x_neg     = vx < prev_x_r;
    y_neg     = vy < prev_y_r;
    adx       = x_neg ? (prev_x_r - vx) : (vx - prev_x_r);
    ady       = y_neg ? (prev_y_r - vy) : (vy - prev_y_r);
    shallow   = adx >= ady;
    is_start  = in_vtx.new_line || !started_r;
    is_repeat = !is_start && (adx == '0) && (ady == '0);
  end

  // One restoring-division step: bring down the next dividend bit.
  always_comb begin
    rem_sh   = {rem_r, num_r[NUM_W-1]};
    rem_ge   = rem_sh >= {1'b0, div_r};
    rem_diff = rem_sh - {1'b0, div_r};
  end

  always_comb begin
    state_nxt   = state_r;
    prev_x_nxt  = prev_x_r;
    prev_y_nxt  = prev_y_r;
    started_nxt = started_r;
    cmd_nxt     = cmd_r;
    num_nxt     = num_r;
    rem_nxt     = rem_r;
    div_nxt     = div_r;
    cnt_nxt     = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          prev_x_nxt    = vx;
          prev_y_nxt    = vy;
          started_nxt   = 1'b1;
          cmd_nxt.x_start = prev_x_r;
          cmd_nxt.y_start = prev_y_r;
          cmd_nxt.x_end   = vx;
          cmd_nxt.y_end   = vy;
          cmd_nxt.d_neg   = shallow ? y_neg : x_neg;
          cmd_nxt.d_mag   = '0;
          num_nxt = {(shallow ? ady : adx), {FRAC_BITS{1'b0}}};
          div_nxt = shallow ? adx : ady;
          rem_nxt = '0;
          cnt_nxt = '0;
          if (is_start) begin
            cmd_nxt.mode = MODE_SINGLE;
            state_nxt    = ST_PUSH;
          end else if (is_repeat) begin
            cmd_nxt.mode = MODE_SINGLE;
          end else begin
            cmd_nxt.mode = shallow ? MODE_SHALLOW : MODE_STEEP;
            state_nxt    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        rem_nxt = rem_ge ? rem_diff[COORD_W-1:0] : rem_sh[COORD_W-1:0];
        num_nxt = {num_r[NUM_W-2:0], rem_ge};
        cnt_nxt = cnt_r + DCNT_W'(1);
        if (cnt_r == DCNT_W'(NUM_W - 1)) begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (!q_stat_i.full) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      prev_x_r  <= '0;
      prev_y_r  <= '0;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      prev_x_r  <= prev_x_nxt;
      prev_y_r  <= prev_y_nxt;
      started_r <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    cnt_r <= cnt_nxt;
  end

  always_comb begin
    cmd_o       = cmd_r;
    cmd_o.d_mag = num_r[DMAG_W-1:0];
  end
  assign push_o = (state_r == ST_PUSH) && !q_stat_i.full;

  // The slope of a walk never exceeds one grid step.
  `ASSERT_IMPLIES(a_slope_le_one, (state_r == ST_PUSH) && (cmd_r.mode != MODE_SINGLE),
    num_r <= (NUM_W'(1) << FRAC_BITS))

endmodule

>>> src/pgw_cmd_queue.sv
// Short command queue between the front end and the walker.
// Depends on pgw_pkg for the command and status types.
`include "assert_macros.svh"

module pgw_cmd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_i,
  input  pgw_pkg::walk_cmd_t wr_cmd_i,
  input  logic               pop_i,
  output pgw_pkg::walk_cmd_t rd_cmd_o,
  output pgw_pkg::q_stat_t   stat_o
);
  import pgw_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  walk_cmd_t         mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push_i) begin
      mem_r[wr_ptr_r] <= wr_cmd_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop_i) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push_i && !pop_i) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  assign rd_cmd_o     = mem_r[rd_ptr_r];
  assign stat_o.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign stat_o.empty = (count_r == '0);

  `ASSERT_IMPLIES(a_no_overflow, push_i, !stat_o.full)
  `ASSERT_IMPLIES(a_no_underflow, pop_i, !stat_o.empty)

endmodule

>>> src/pgw_back.sv
// Back end: walks one segment a point per cycle while the output is not stalled,
// into the output register. Depends on pgw_pkg and pgw_ifs.
`include "assert_macros.svh"

module pgw_back (
  input  logic               clk,
  input  logic               rst_n,
  input  pgw_pkg::q_stat_t   q_stat_i,
  input  pgw_pkg::walk_cmd_t cmd_i,
  output logic               pop_o,
  pgw_out_if.source          out_pt
);
  import pgw_pkg::*;

  logic              busy_r, busy_nxt;
  logic              out_valid_r, out_valid_nxt;
  mode_t             mode_r, mode_nxt;
  coord_t            maj_r, maj_nxt;
  coord_t            maj_end_r, maj_end_nxt;
  coord_t            min_end_r, min_end_nxt;
  logic              maj_neg_r, maj_neg_nxt;
  logic              d_neg_r, d_neg_nxt;
  logic [DMAG_W-1:0] d_mag_r, d_mag_nxt;
  logic [CARRY_W-1:0] c_r, c_nxt;
  logic [RCNT_W-1:0] cnt_r, cnt_nxt;
  coord_t            out_x_r, out_x_nxt;
  coord_t            out_y_r, out_y_nxt;
  logic              out_last_r, out_last_nxt;

  logic             out_free, step, shallow, cmd_shallow, over, walk_last;
  coord_t           maj_inc, maj_n, min_out;
  logic [CARRY_W-1:0] c_n;
  logic [COORD_W:0] tr;

  assign out_free = !out_valid_r || out_pt.ready;
  assign pop_o    = !busy_r && !q_stat_i.empty && out_free;
  assign step     = busy_r && out_free;

  always_comb begin
    shallow = (mode_r == MODE_SHALLOW);
    maj_inc = maj_neg_r ? (maj_r - coord_t'(1)) : (maj_r + coord_t'(1));
    // A steep walk holds its major coordinate once it reaches the end.
    maj_n   = (!shallow && (maj_r == maj_end_r)) ? maj_end_r : maj_inc;
    c_n     = d_neg_r ? (c_r - CARRY_W'(d_mag_r)) : (c_r + CARRY_W'(d_mag_r));
    tr      = c_n[CARRY_W-1:FRAC_BITS];
    over    = d_neg_r ? (tr < {1'b0, min_end_r}) : (tr > {1'b0, min_end_r});
    if (shallow) begin
      min_out   = (maj_n == maj_end_r) ? min_end_r : tr[COORD_W-1:0];
      walk_last = (maj_n == maj_end_r);
    end else begin
      min_out   = over ? min_end_r : tr[COORD_W-1:0];
      walk_last = ((maj_n == maj_end_r) && (min_out == min_end_r)) ||
                  (cnt_r == RCNT_W'(MAX_RES - 1));
    end
  end

  always_comb begin
    cmd_shallow   = (cmd_i.mode == MODE_SHALLOW);
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    mode_nxt      = mode_r;
    maj_nxt       = maj_r;
    maj_end_nxt   = maj_end_r;
    min_end_nxt   = min_end_r;
    maj_neg_nxt   = maj_neg_r;
    d_neg_nxt     = d_neg_r;
    d_mag_nxt     = d_mag_r;
    c_nxt         = c_r;
    cnt_nxt       = cnt_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_last_nxt  = out_last_r;
    if (out_free) begin
      out_valid_nxt = 1'b0;
    end
    if (pop_o) begin
      if (cmd_i.mode == MODE_SINGLE) begin
        out_valid_nxt = 1'b1;
        out_x_nxt     = cmd_i.x_end;
        out_y_nxt     = cmd_i.y_end;
        out_last_nxt  = 1'b1;
      end else begin
        busy_nxt    = 1'b1;
        mode_nxt    = cmd_i.mode;
        maj_nxt     = cmd_shallow ? cmd_i.x_start : cmd_i.y_start;
        maj_end_nxt = cmd_shallow ? cmd_i.x_end : cmd_i.y_end;
        min_end_nxt = cmd_shallow ? cmd_i.y_end : cmd_i.x_end;
        maj_neg_nxt = cmd_shallow ? (cmd_i.x_end < cmd_i.x_start)
                                  : (cmd_i.y_end < cmd_i.y_start);
        d_neg_nxt   = cmd_i.d_neg;
        d_mag_nxt   = cmd_i.d_mag;
        c_nxt       = {1'b0, (cmd_shallow ? cmd_i.y_start : cmd_i.x_start),
                       {FRAC_BITS{1'b0}}};
        cnt_nxt     = '0;
      end
    end
    if (step) begin
      out_valid_nxt = 1'b1;
      out_x_nxt     = shallow ? maj_n : min_out;
      out_y_nxt     = shallow ? min_out : maj_n;
      out_last_nxt  = walk_last;
      maj_nxt       = maj_n;
      c_nxt         = c_n;
      cnt_nxt       = cnt_r + RCNT_W'(1);
      if (walk_last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    maj_r      <= maj_nxt;
    maj_end_r  <= maj_end_nxt;
    min_end_r  <= min_end_nxt;
    maj_neg_r  <= maj_neg_nxt;
    d_neg_r    <= d_neg_nxt;
    d_mag_r    <= d_mag_nxt;
    c_r        <= c_nxt;
    cnt_r      <= cnt_nxt;
    out_x_r    <= out_x_nxt;
    out_y_r    <= out_y_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_pt.valid      = out_valid_r;
  assign out_pt.point_x    = out_x_r;
  assign out_pt.point_y    = out_y_r;
  assign out_pt.last_point = out_last_r;

  // A shallow walk stops on its endpoint and never sits on it while busy.
  `ASSERT_IMPLIES(a_shallow_before_end, busy_r && (mode_r == MODE_SHALLOW),
    maj_r != maj_end_r)
  `ASSERT_NEXT(a_last_ends_walk, step && walk_last, !busy_r)

endmodule

>>> src/polyline_grid_walker_unit.sv
// Polyline grid walker: emits every grid point of a polyline given as vertices.
// A start vertex is accepted and pushed to the queue by the front end, then gives
// one output beat. A repeated vertex is only accepted and emits nothing. Any other
// vertex is accepted, has its slope found by a one-bit-per-cycle divider and is
// pushed to the queue by the front end, then is popped by the walker, which gives
// one output beat per emitted point (at most 64). A two-entry command queue lets
// the front end accept and divide the next segment while the walker still emits;
// output backpressure stalls the walker and, once the queue is full, the front
// end. last_point marks the final point caused by each vertex.
// Depends on pgw_pkg, pgw_ifs, pgw_front, pgw_cmd_queue and pgw_back.

module polyline_grid_walker_unit (
  input  logic      clk,
  input  logic      rst_n,
  pgw_in_if.sink    in_vtx,
  pgw_out_if.source out_pt
);
  import pgw_pkg::*;

  logic      push, pop;
  walk_cmd_t wr_cmd, rd_cmd;
  q_stat_t   q_stat;

  pgw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vtx   (in_vtx),
    .push_o   (push),
    .cmd_o    (wr_cmd),
    .q_stat_i (q_stat)
  );

  pgw_cmd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (push),
    .wr_cmd_i (wr_cmd),
    .pop_i    (pop),
    .rd_cmd_o (rd_cmd),
    .stat_o   (q_stat)
  );

  pgw_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat_i (q_stat),
    .cmd_i    (rd_cmd),
    .pop_o    (pop),
    .out_pt   (out_pt)
  );

endmodule
